// ----- src/cob_pkg.sv -----
`default_nettype none

package cob_pkg;

  // Fraction bits of the balance outputs
  localparam int FRAC_BITS = 15;

  localparam int LOAD_W = 16;
  localparam int OUT_W  = 16;
  localparam int SUM_W  = LOAD_W + 1;
  localparam int TOT_W  = LOAD_W + 2;
  localparam int REM_W  = TOT_W + 1;

  // Quotient holds values up to 1.0, so one bit above the fraction
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int SAT_W  = (QUO_W > OUT_W + 1) ? QUO_W : OUT_W + 1;

  localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN_MAG = 1 << (OUT_W - 1);

  // One item as it moves down the divider chain
  typedef struct packed {
    logic             valid;
    logic             no_load;
    logic             neg_x;
    logic             neg_y;
    logic [TOT_W-1:0] total;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
  } stage_t;

endpackage

`default_nettype wire

// ----- src/center_of_balance_from_load_cells.sv -----
// Center of balance from four load cells. Raise start with the four readings
// and one item is taken every clock cycle; busy stays low. Each result goes
// through a front register that forms the sums, then one divider cell per
// quotient bit, most significant first, and then one output register.
// done marks the result for exactly one cycle and there is no way to hold it,
// so the receiver must take it then. balance_x = (right - left) / total and
// balance_y = (top - bottom) / total, Q1.15, truncated toward zero, with +1.0
// clamped to 32767. A zero total gives zero outputs with no_load set.
`default_nettype none

module center_of_balance_from_load_cells (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cob_pkg::LOAD_W-1:0]         load_top_right,
  input  wire logic [cob_pkg::LOAD_W-1:0]         load_bottom_right,
  input  wire logic [cob_pkg::LOAD_W-1:0]         load_top_left,
  input  wire logic [cob_pkg::LOAD_W-1:0]         load_bottom_left,
  output logic                                    done,
  output logic signed [cob_pkg::OUT_W-1:0]        balance_x,
  output logic signed [cob_pkg::OUT_W-1:0]        balance_y,
  output logic                                    no_load
);

  cob_pkg::stage_t chain [cob_pkg::QUO_W+1];

  // The pipeline never stalls
  assign busy = 1'b0;

  cob_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .load_top_right    (load_top_right),
    .load_bottom_right (load_bottom_right),
    .load_top_left     (load_top_left),
    .load_bottom_left  (load_bottom_left),
    .stage             (chain[0])
  );

  // One cell per quotient bit, most significant first
  for (genvar i = 0; i < cob_pkg::QUO_W; i++) begin : g_cell
    cob_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  cob_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stage     (chain[cob_pkg::QUO_W]),
    .done      (done),
    .balance_x (balance_x),
    .balance_y (balance_y),
    .no_load   (no_load)
  );

endmodule

`default_nettype wire

// ----- src/cob_front.sv -----
`default_nettype none

module cob_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [cob_pkg::LOAD_W-1:0]    load_top_right,
  input  wire logic [cob_pkg::LOAD_W-1:0]    load_bottom_right,
  input  wire logic [cob_pkg::LOAD_W-1:0]    load_top_left,
  input  wire logic [cob_pkg::LOAD_W-1:0]    load_bottom_left,
  output cob_pkg::stage_t                    stage
);

  logic [cob_pkg::SUM_W-1:0] right, left, top, bottom;
  logic [cob_pkg::SUM_W-1:0] mag_x, mag_y;
  logic [cob_pkg::TOT_W-1:0] total;
  logic                      neg_x, neg_y;
  cob_pkg::stage_t           stage_next;

  // Form the side sums and the signed differences as magnitude and sign
  always_comb begin
    right  = {1'b0, load_top_right} + {1'b0, load_bottom_right};
    left   = {1'b0, load_top_left} + {1'b0, load_bottom_left};
    top    = {1'b0, load_top_right} + {1'b0, load_top_left};
    bottom = {1'b0, load_bottom_right} + {1'b0, load_bottom_left};
    total  = {1'b0, right} + {1'b0, left};
    neg_x  = left > right;
    neg_y  = bottom > top;
    mag_x  = neg_x ? (left - right) : (right - left);
    mag_y  = neg_y ? (bottom - top) : (top - bottom);

    stage_next         = '0;
    stage_next.valid   = start;
    stage_next.no_load = (total == '0);
    stage_next.neg_x   = neg_x;
    stage_next.neg_y   = neg_y;
    stage_next.total   = total;
    stage_next.rem_x   = {2'b00, mag_x};
    stage_next.rem_y   = {2'b00, mag_y};
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cob_cell.sv -----
`default_nettype none

module cob_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  cob_pkg::stage_t stage_in,
  output cob_pkg::stage_t stage_out
);

  logic                      ge_x, ge_y;
  logic [cob_pkg::REM_W-1:0] total_ext;
  logic [cob_pkg::REM_W-1:0] sub_x, sub_y;
  logic [cob_pkg::TOT_W-1:0] kept_x, kept_y;
  cob_pkg::stage_t           stage_next;

  // Trial subtract on both axes, keep one quotient bit each, double remainder
  always_comb begin
    total_ext = {1'b0, stage_in.total};
    ge_x      = stage_in.rem_x >= total_ext;
    ge_y      = stage_in.rem_y >= total_ext;
    sub_x     = stage_in.rem_x - total_ext;
    sub_y     = stage_in.rem_y - total_ext;
    kept_x    = ge_x ? sub_x[cob_pkg::TOT_W-1:0] : stage_in.rem_x[cob_pkg::TOT_W-1:0];
    kept_y    = ge_y ? sub_y[cob_pkg::TOT_W-1:0] : stage_in.rem_y[cob_pkg::TOT_W-1:0];

    stage_next       = stage_in;
    stage_next.rem_x = {kept_x, 1'b0};
    stage_next.rem_y = {kept_y, 1'b0};
    stage_next.quo_x = {stage_in.quo_x[cob_pkg::QUO_W-2:0], ge_x};
    stage_next.quo_y = {stage_in.quo_y[cob_pkg::QUO_W-2:0], ge_y};
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out <= '0;
    end else begin
      stage_out <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cob_back.sv -----
`default_nettype none

module cob_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  cob_pkg::stage_t                  stage,
  output logic                             done,
  output logic signed [cob_pkg::OUT_W-1:0] balance_x,
  output logic signed [cob_pkg::OUT_W-1:0] balance_y,
  output logic                             no_load
);

  logic [cob_pkg::OUT_W-1:0] x_next, y_next;

  function automatic logic [cob_pkg::OUT_W-1:0] saturate(
    input logic [cob_pkg::QUO_W-1:0] quo,
    input logic                      neg
  );
    logic [cob_pkg::SAT_W-1:0] q;
    logic [cob_pkg::SAT_W-1:0] lim;
    q   = cob_pkg::SAT_W'(quo);
    lim = neg ? cob_pkg::SAT_W'(cob_pkg::OUT_MIN_MAG) : cob_pkg::SAT_W'(cob_pkg::OUT_MAX);
    if (q > lim) begin
      q = lim;
    end
    if (neg) begin
      q = -q;
    end
    return q[cob_pkg::OUT_W-1:0];
  endfunction

  // Clamp, apply sign, zero on no load
  always_comb begin
    x_next = saturate(stage.quo_x, stage.neg_x);
    y_next = saturate(stage.quo_y, stage.neg_y);
    if (stage.no_load) begin
      x_next = '0;
      y_next = '0;
    end
  end

  // Hold the result for one cycle with its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    balance_x <= x_next;
    balance_y <= y_next;
    no_load   <= stage.no_load;
  end

endmodule

`default_nettype wire
